### rtl/bf3_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bf3_pkg: shared types and constants of the 3x3 RGB box filter
// Pixel layout, stream payloads, stage records and register indexes.
// ----------------------------------------------------------------------------
package bf3_pkg;

  localparam int CH_N      = 3;
  localparam int CH_W      = 8;
  localparam int TAG_W     = 10;
  localparam int CFG_W     = 11;
  localparam int CFG_IDX_W = 2;
  localparam int COLSUM_W  = 10;
  localparam int SUM_W     = 12;
  localparam int MUL_W     = 13;
  localparam int PROD_W    = SUM_W + MUL_W;

  // Reciprocal of nine: exact floor for every sum below 32768.
  localparam int DIV9_MUL   = 7282;
  localparam int DIV9_SHIFT = 16;

  localparam int FRAME_WIDTH_RST  = 352;
  localparam int FRAME_HEIGHT_RST = 288;

  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 2'd1;

  // Channel 2 is red, 1 is green, 0 is blue.
  typedef logic [CH_N-1:0][CH_W-1:0] pixel_t;

  typedef struct packed {
    pixel_t older;
    pixel_t prev;
  } line_t;

  typedef struct packed {
    logic [CH_W-1:0] red_in;
    logic [CH_W-1:0] green_in;
    logic [CH_W-1:0] blue_in;
  } pix_in_t;

  typedef struct packed {
    logic [CH_W-1:0]  red_out;
    logic [CH_W-1:0]  green_out;
    logic [CH_W-1:0]  blue_out;
    logic [TAG_W-1:0] pixel_row;
    logic [TAG_W-1:0] pixel_col;
    logic             last_of_run;
  } pix_out_t;

  typedef struct packed {
    logic has_win;
    logic interior;
    logic has_rowend;
    logic has_last;
  } flags_t;

  typedef struct packed {
    flags_t                     flags;
    logic [CH_N-1:0][SUM_W-1:0] sum;
    pixel_t                     pass0;
    pixel_t                     mid;
    pixel_t                     px;
    logic [TAG_W-1:0]           row;
    logic [TAG_W-1:0]           col;
  } win_item_t;

endpackage
`default_nettype wire

### rtl/bf3_stream_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bf3_stream_if: valid/ready stream channel
// Carries one item of payload type T per accepted handshake.
// ----------------------------------------------------------------------------
interface bf3_stream_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

### rtl/bf3_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bf3_ctrl: frame size registers and raster position
// Holds the clamped frame size, counts row and column of the next item and
// decodes which results that item will cause.
// ----------------------------------------------------------------------------
module bf3_ctrl #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024,
  parameter int CW         = $clog2(MAX_WIDTH),
  parameter int RW         = $clog2(MAX_HEIGHT)
) (
  input  wire                            clk_i,
  input  wire                            rst_ni,
  input  wire                            cfg_we_i,
  input  wire [bf3_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  wire [bf3_pkg::CFG_W-1:0]       cfg_wdata_i,
  input  wire                            in_fire_i,
  output logic [CW-1:0]                  addr_o,
  output bf3_pkg::flags_t                flags_o,
  output logic [bf3_pkg::TAG_W-1:0]      tag_row_o,
  output logic [bf3_pkg::TAG_W-1:0]      tag_col_o
);
  import bf3_pkg::*;

  localparam int WW    = $clog2(MAX_WIDTH + 1);
  localparam int HW    = $clog2(MAX_HEIGHT + 1);
  localparam int RST_W = (FRAME_WIDTH_RST > MAX_WIDTH) ? MAX_WIDTH : FRAME_WIDTH_RST;
  localparam int RST_H = (FRAME_HEIGHT_RST > MAX_HEIGHT) ? MAX_HEIGHT : FRAME_HEIGHT_RST;

  logic [WW-1:0] width_q, width_d;
  logic [HW-1:0] height_q, height_d;
  logic [CW-1:0] col_q, col_d;
  logic [RW-1:0] row_q, row_d;
  logic [WW-1:0] clamp_w;
  logic [HW-1:0] clamp_h;
  logic          col_last, row_last;

  always_comb begin
    if (cfg_wdata_i == '0) begin
      clamp_w = WW'(1);
      clamp_h = HW'(1);
    end else begin
      clamp_w = (int'(cfg_wdata_i) > MAX_WIDTH) ? WW'(MAX_WIDTH) : WW'(cfg_wdata_i);
      clamp_h = (int'(cfg_wdata_i) > MAX_HEIGHT) ? HW'(MAX_HEIGHT) : HW'(cfg_wdata_i);
    end
  end

  assign col_last = (WW'(col_q) + WW'(1)) == width_q;
  assign row_last = (HW'(row_q) + HW'(1)) == height_q;

  always_comb begin
    width_d  = width_q;
    height_d = height_q;
    col_d    = col_q;
    row_d    = row_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_FRAME_WIDTH: begin
          width_d = clamp_w;
          col_d   = '0;
          row_d   = '0;
        end
        REG_FRAME_HEIGHT: begin
          height_d = clamp_h;
          col_d    = '0;
          row_d    = '0;
        end
        default: begin
        end
      endcase
    end else if (in_fire_i) begin
      if (col_last) begin
        col_d = '0;
        row_d = row_last ? '0 : row_q + RW'(1);
      end else begin
        col_d = col_q + CW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= WW'(RST_W);
      height_q <= HW'(RST_H);
      col_q    <= '0;
      row_q    <= '0;
    end else begin
      width_q  <= width_d;
      height_q <= height_d;
      col_q    <= col_d;
      row_q    <= row_d;
    end
  end

  assign addr_o              = col_q;
  assign tag_row_o           = TAG_W'(row_q);
  assign tag_col_o           = TAG_W'(col_q);
  assign flags_o.has_win     = (row_q != '0) && (col_q != '0);
  assign flags_o.interior    = (row_q >= RW'(2)) && (col_q >= CW'(2));
  assign flags_o.has_rowend  = (row_q != '0) && col_last;
  assign flags_o.has_last    = row_last;

endmodule
`default_nettype wire

### rtl/bf3_line_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bf3_line_ram: line buffer memory
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module bf3_line_ram #(
  parameter int DEPTH = 1024,
  parameter int AW    = $clog2(DEPTH),
  parameter int DW    = 48
) (
  input  wire           clk_i,
  input  wire           we_i,
  input  wire [AW-1:0]  waddr_i,
  input  wire [DW-1:0]  wdata_i,
  input  wire           re_i,
  input  wire [AW-1:0]  raddr_i,
  output logic [DW-1:0] rdata_o
);
  logic [DW-1:0] mem [DEPTH];
  logic [DW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

### rtl/bf3_window.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bf3_window: line buffer read-modify-write and window sums
// Reads both stored lines at the item's column, forms the new column sum,
// adds the two earlier column sums and writes the shifted lines back.
// ----------------------------------------------------------------------------
module bf3_window #(
  parameter int MAX_WIDTH = 1024,
  parameter int CW        = $clog2(MAX_WIDTH)
) (
  input  wire                           clk_i,
  input  wire                           rst_ni,
  input  wire                           in_valid_i,
  output logic                          in_ready_o,
  input  bf3_pkg::pixel_t               px_i,
  input  wire [CW-1:0]                  addr_i,
  input  bf3_pkg::flags_t               flags_i,
  input  wire [bf3_pkg::TAG_W-1:0]      tag_row_i,
  input  wire [bf3_pkg::TAG_W-1:0]      tag_col_i,
  output logic                          item_valid_o,
  input  wire                           item_ready_i,
  output bf3_pkg::win_item_t            item_o
);
  import bf3_pkg::*;

  logic                           s1_valid_q;
  pixel_t                         px_q;
  logic [CW-1:0]                  addr_q;
  flags_t                         flags_q;
  logic [TAG_W-1:0]               row_q;
  logic [TAG_W-1:0]               col_q;
  logic                           fwd_q;
  line_t                          fwd_data_q;
  logic [CH_N-1:0][COLSUM_W-1:0]  cs1_q;
  logic [CH_N-1:0][COLSUM_W-1:0]  cs2_q;
  pixel_t                         mid1_q;

  logic                           in_fire, s1_fire;
  line_t                          rd_line, cur_line, wr_line;
  logic [CH_N-1:0][COLSUM_W-1:0]  colsum;
  logic [CH_N-1:0][SUM_W-1:0]     sum;

  assign s1_fire    = s1_valid_q && item_ready_i;
  assign in_ready_o = !s1_valid_q || item_ready_i;
  assign in_fire    = in_valid_i && in_ready_o;

  bf3_line_ram #(
    .DEPTH (MAX_WIDTH),
    .AW    (CW),
    .DW    ($bits(line_t))
  ) u_line_ram (
    .clk_i   (clk_i),
    .we_i    (s1_fire),
    .waddr_i (addr_q),
    .wdata_i (wr_line),
    .re_i    (in_fire),
    .raddr_i (addr_i),
    .rdata_o (rd_line)
  );

  assign cur_line      = fwd_q ? fwd_data_q : rd_line;
  assign wr_line.older = cur_line.prev;
  assign wr_line.prev  = px_q;

  always_comb begin
    for (int k = 0; k < CH_N; k++) begin
      colsum[k] = COLSUM_W'(cur_line.older[k]) + COLSUM_W'(cur_line.prev[k])
                + COLSUM_W'(px_q[k]);
      sum[k]    = SUM_W'(colsum[k]) + SUM_W'(cs1_q[k]) + SUM_W'(cs2_q[k]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_fire) begin
      s1_valid_q <= 1'b1;
    end else if (s1_fire) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      px_q       <= px_i;
      addr_q     <= addr_i;
      flags_q    <= flags_i;
      row_q      <= tag_row_i;
      col_q      <= tag_col_i;
      fwd_q      <= s1_fire && (addr_q == addr_i);
      fwd_data_q <= wr_line;
    end
    if (s1_fire) begin
      cs1_q  <= colsum;
      cs2_q  <= cs1_q;
      mid1_q <= cur_line.prev;
    end
  end

  assign item_valid_o = s1_valid_q;
  assign item_o.flags = flags_q;
  assign item_o.sum   = sum;
  assign item_o.pass0 = mid1_q;
  assign item_o.mid   = cur_line.prev;
  assign item_o.px    = px_q;
  assign item_o.row   = row_q;
  assign item_o.col   = col_q;

endmodule
`default_nettype wire

### rtl/bf3_emit.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bf3_emit: division and result sequencing
// Holds one item, divides its window sums by nine and hands its results,
// up to three, to the output register one per cycle while the output is not stalled.
// ----------------------------------------------------------------------------
module bf3_emit (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  item_valid_i,
  output logic                 item_ready_o,
  input  bf3_pkg::win_item_t   item_i,
  output logic                 out_valid_o,
  input  wire                  out_ready_i,
  output bf3_pkg::pix_out_t    out_o
);
  import bf3_pkg::*;

  logic       s2_valid_q;
  win_item_t  item_q;
  logic [2:0] pend_q;
  logic       out_valid_q;
  pix_out_t   out_q;

  logic [2:0]                 sel, pend_next;
  logic                       out_load, emit_now, finish, item_load;
  logic [CH_N-1:0][PROD_W-1:0] prod;
  pixel_t                     quot, res_px;
  logic [TAG_W-1:0]           res_row, res_col;

  always_comb begin
    for (int k = 0; k < CH_N; k++) begin
      prod[k] = PROD_W'(item_q.sum[k]) * PROD_W'(DIV9_MUL);
      quot[k] = prod[k][DIV9_SHIFT +: CH_W];
    end
  end

  assign sel       = pend_q & (~pend_q + 3'd1);
  assign pend_next = pend_q & ~sel;
  assign out_load  = !out_valid_q || out_ready_i;
  assign emit_now  = s2_valid_q && (pend_q != 3'd0) && out_load;
  assign finish    = s2_valid_q && ((pend_q == 3'd0) || (emit_now && (pend_next == 3'd0)));
  assign item_ready_o = !s2_valid_q || finish;
  assign item_load    = item_valid_i && item_ready_o;

  always_comb begin
    res_px  = item_q.px;
    res_row = item_q.row;
    res_col = item_q.col;
    if (sel[0]) begin
      res_px  = item_q.flags.interior ? quot : item_q.pass0;
      res_row = item_q.row - TAG_W'(1);
      res_col = item_q.col - TAG_W'(1);
    end else if (sel[1]) begin
      res_px  = item_q.mid;
      res_row = item_q.row - TAG_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q  <= 1'b0;
      pend_q      <= 3'd0;
      out_valid_q <= 1'b0;
    end else begin
      if (item_load) begin
        s2_valid_q <= 1'b1;
        pend_q     <= {item_i.flags.has_last, item_i.flags.has_rowend, item_i.flags.has_win};
      end else begin
        if (finish) begin
          s2_valid_q <= 1'b0;
        end
        if (emit_now) begin
          pend_q <= pend_next;
        end
      end
      if (emit_now) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (item_load) begin
      item_q <= item_i;
    end
    if (emit_now) begin
      out_q.red_out     <= res_px[2];
      out_q.green_out   <= res_px[1];
      out_q.blue_out    <= res_px[0];
      out_q.pixel_row   <= res_row;
      out_q.pixel_col   <= res_col;
      out_q.last_of_run <= (pend_next == 3'd0);
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

endmodule
`default_nettype wire

### rtl/box_filter_3x3_rgb.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// box_filter_3x3_rgb: streaming 3x3 mean filter for RGB pixels
// Interior pixels become the per-channel floor of the 3x3 mean, border
// pixels pass through; results are tagged with their position and trail their
// item by up to one row and one column.
//
//   Channel   Dir  Handshake            Payload
//   pix_i     in   valid / ready        red_in, green_in, blue_in
//   pix_o     out  valid / ready        RGB, pixel_row, pixel_col, last_of_run
//   cfg       in   cfg_we_i (no stall)  cfg_idx_i, cfg_wdata_i
//
// One item is taken per cycle while the output is not stalled; an item with two or
// three results holds the input while the single output register takes its extra results.
// Items pass the window stage and the emit stage, results the output register.
// Reset sets the frame to 352 x 288 and the position to the first pixel; the
// line memory is not cleared. A stalled output backs up through both stages.
// ----------------------------------------------------------------------------
module box_filter_3x3_rgb #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024
) (
  input  wire                            clk_i,
  input  wire                            rst_ni,
  bf3_stream_if.sink                     pix_i,
  bf3_stream_if.source                   pix_o,
  input  wire                            cfg_we_i,
  input  wire [bf3_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  wire [bf3_pkg::CFG_W-1:0]       cfg_wdata_i
);
  import bf3_pkg::*;

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int RW = $clog2(MAX_HEIGHT);

  logic             in_ready;
  logic             in_fire;
  logic [CW-1:0]    addr;
  flags_t           flags;
  logic [TAG_W-1:0] tag_row, tag_col;
  pixel_t           px;
  logic             win_valid, win_ready;
  win_item_t        win_item;

  assign in_fire     = pix_i.valid && in_ready;
  assign pix_i.ready = in_ready;
  assign px          = {pix_i.data.red_in, pix_i.data.green_in, pix_i.data.blue_in};

  bf3_ctrl #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT),
    .CW         (CW),
    .RW         (RW)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_fire_i   (in_fire),
    .addr_o      (addr),
    .flags_o     (flags),
    .tag_row_o   (tag_row),
    .tag_col_o   (tag_col)
  );

  bf3_window #(
    .MAX_WIDTH (MAX_WIDTH),
    .CW        (CW)
  ) u_window (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (pix_i.valid),
    .in_ready_o   (in_ready),
    .px_i         (px),
    .addr_i       (addr),
    .flags_i      (flags),
    .tag_row_i    (tag_row),
    .tag_col_i    (tag_col),
    .item_valid_o (win_valid),
    .item_ready_i (win_ready),
    .item_o       (win_item)
  );

  bf3_emit u_emit (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_valid_i (win_valid),
    .item_ready_o (win_ready),
    .item_i       (win_item),
    .out_valid_o  (pix_o.valid),
    .out_ready_i  (pix_o.ready),
    .out_o        (pix_o.data)
  );

`ifndef SYNTH
  a_fire_fills_window: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> win_valid)
    else $error("accepted item did not reach the window stage");

  a_interior_has_win: assert property (@(posedge clk_i) disable iff (!rst_ni)
    win_valid |-> (!win_item.flags.interior || win_item.flags.has_win))
    else $error("interior item without a window result");

  a_run_continues: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pix_o.valid && pix_o.ready && !pix_o.data.last_of_run) |=> pix_o.valid)
    else $error("result run broken before its last result");
`endif

endmodule
`default_nettype wire
